FILE: src/sct_pkg.sv
// Shared types, codes and character classifiers for the source code tokenizer.
package sct_pkg;

  // Token kinds
  localparam logic [4:0] K_IDENT    = 5'd0;
  localparam logic [4:0] K_NUMBER   = 5'd1;
  localparam logic [4:0] K_STRING   = 5'd2;
  localparam logic [4:0] K_ASSIGN   = 5'd3;
  localparam logic [4:0] K_COMPARE  = 5'd4;
  localparam logic [4:0] K_OPERATOR = 5'd5;
  localparam logic [4:0] K_LPAREN   = 5'd6;
  localparam logic [4:0] K_RPAREN   = 5'd7;
  localparam logic [4:0] K_LBRACE   = 5'd8;
  localparam logic [4:0] K_RBRACE   = 5'd9;
  localparam logic [4:0] K_LBRACKET = 5'd10;
  localparam logic [4:0] K_RBRACKET = 5'd11;
  localparam logic [4:0] K_COMMA    = 5'd12;
  localparam logic [4:0] K_COLON    = 5'd13;
  localparam logic [4:0] K_SEMI     = 5'd14;
  localparam logic [4:0] K_DOT      = 5'd15;
  localparam logic [4:0] K_UNKNOWN  = 5'd16;

  // Characters with a role of their own
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_RBRKT  = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // Result queue depth
  localparam int unsigned QDEPTH = 3;

  // Lexer modes, one-hot
  typedef enum logic [5:0] {
    M_IDLE     = 6'b000001,
    M_IDENT    = 6'b000010,
    M_NUMBER   = 6'b000100,
    M_STR_OPEN = 6'b001000,
    M_STR      = 6'b010000,
    M_OP       = 6'b100000
  } mode_t;

  // One result beat
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic       has_char;
    logic       first;
    logic       last;
    logic       run_end;
  } tok_t;

  // Results of one accepted character, in order
  typedef struct packed {
    logic [1:0] n;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  // Kind lookup with a hit flag
  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } kind_hit_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG) ||
           (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_PCT);
  endfunction

  function automatic kind_hit_t punct_kind(input logic [7:0] c);
    kind_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      CH_LPAREN: r.kind = K_LPAREN;
      CH_RPAREN: r.kind = K_RPAREN;
      CH_LBRACE: r.kind = K_LBRACE;
      CH_RBRACE: r.kind = K_RBRACE;
      CH_LBRKT:  r.kind = K_LBRACKET;
      CH_RBRKT:  r.kind = K_RBRACKET;
      CH_COMMA:  r.kind = K_COMMA;
      CH_COLON:  r.kind = K_COLON;
      CH_SEMI:   r.kind = K_SEMI;
      CH_DOT:    r.kind = K_DOT;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  function automatic logic [4:0] op_single_kind(input logic [7:0] h);
    logic [4:0] k;
    if (h == CH_EQ) begin
      k = K_ASSIGN;
    end else if ((h == CH_LT) || (h == CH_GT)) begin
      k = K_COMPARE;
    end else begin
      k = K_OPERATOR;
    end
    return k;
  endfunction

  // Two-character operator formed by held char h and next char c
  function automatic kind_hit_t op_pair_kind(input logic [7:0] h, input logic [7:0] c);
    kind_hit_t r;
    r.hit  = 1'b0;
    r.kind = K_OPERATOR;
    if (h == CH_EQ) begin
      r.hit  = (c == CH_EQ);
      r.kind = K_COMPARE;
    end else if ((h == CH_LT) || (h == CH_GT)) begin
      if (c == h) begin
        r.hit  = 1'b1;
        r.kind = K_OPERATOR;
      end else begin
        r.hit  = (c == CH_EQ);
        r.kind = K_COMPARE;
      end
    end else if (h == CH_BANG) begin
      r.hit  = (c == CH_EQ);
      r.kind = K_COMPARE;
    end else begin
      r.hit  = (c == CH_EQ);
      r.kind = K_ASSIGN;
    end
    return r;
  endfunction

  // Result for the held character
  function automatic tok_t flush_tok(input mode_t m, input logic [7:0] h,
                                     input logic first, input logic last);
    tok_t t;
    if (m == M_IDENT) begin
      t.kind = K_IDENT;
    end else if (m == M_NUMBER) begin
      t.kind = K_NUMBER;
    end else if (m == M_STR) begin
      t.kind = K_STRING;
    end else begin
      t.kind = op_single_kind(h);
    end
    t.ch       = h;
    t.has_char = 1'b1;
    t.first    = first;
    t.last     = last;
    t.run_end  = 1'b0;
    return t;
  endfunction

  function automatic tok_t make_tok(input logic [4:0] kind, input logic [7:0] ch,
                                    input logic has, input logic first, input logic last);
    tok_t t;
    t.kind     = kind;
    t.ch       = ch;
    t.has_char = has;
    t.first    = first;
    t.last     = last;
    t.run_end  = 1'b0;
    return t;
  endfunction

endpackage

FILE: src/source_code_tokenizer.sv
// Top level of the source code tokenizer: lexer plus result queue.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | in_char_in[7:0], in_end_of_input
//  out_    | output    | out_valid/out_stall| token kind, char, has_char, first, last, run_end
//
// One character is taken per cycle while in_stall is low; its zero to two results go
// into a three-entry queue and leave one beat per cycle while out_stall is low, so an
// item with two results leaves as two beats. The input stalls while two or more beats wait.
// Reset (rst_n low, synchronous) returns the lexer to idle and empties the queue.
module source_code_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_token_kind,
  output logic [7:0] out_char_out,
  output logic       out_has_char,
  output logic       out_token_first,
  output logic       out_token_last,
  output logic       out_run_end
);

  logic           take;
  logic           nearly_full;
  sct_pkg::push_t push;
  sct_pkg::tok_t  head;

  assign in_stall = nearly_full;
  assign take     = in_valid && !nearly_full;

  sct_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .char_in      (in_char_in),
    .end_of_input (in_end_of_input),
    .push         (push)
  );

  sct_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .nearly_full (nearly_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .head        (head)
  );

  // Output fields
  assign out_token_kind  = head.kind;
  assign out_char_out    = head.ch;
  assign out_has_char    = head.has_char;
  assign out_token_first = head.first;
  assign out_token_last  = head.last;
  assign out_run_end     = head.run_end;

endmodule

FILE: src/sct_lexer.sv
// Lexer state and per-character classification producing up to two results.
module sct_lexer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     char_in,
  input  logic           end_of_input,
  output sct_pkg::push_t push
);

  typedef struct packed {
    logic          v;
    sct_pkg::tok_t tok;
  } cand_t;

  sct_pkg::mode_t mode_r, mode_nxt, mode1;
  logic [7:0]     hc_r, hc_nxt, hc1;
  logic           hv_r, hv_nxt, hv1;
  logic           hf_r, hf_nxt, hf1;

  cand_t             ca, cb, ce;
  logic              do_start;
  logic              cont;
  sct_pkg::kind_hit_t pair;
  sct_pkg::kind_hit_t pk;
  logic [1:0]        n;
  sct_pkg::tok_t     r0, r1;

  // Main transition on the incoming character
  always_comb begin
    mode1    = mode_r;
    hc1      = hc_r;
    hv1      = hv_r;
    hf1      = hf_r;
    ca       = '0;
    cb       = '0;
    do_start = 1'b0;
    cont     = 1'b0;
    pair     = sct_pkg::op_pair_kind(hc_r, char_in);
    pk       = sct_pkg::punct_kind(char_in);

    unique case (mode_r)
      sct_pkg::M_IDENT, sct_pkg::M_NUMBER: begin
        cont = (mode_r == sct_pkg::M_IDENT) ? sct_pkg::is_word(char_in) :
               (sct_pkg::is_digit(char_in) || (char_in == sct_pkg::CH_DOT));
        if (cont && hv_r) begin
          ca.v   = 1'b1;
          ca.tok = sct_pkg::flush_tok(mode_r, hc_r, hf_r, 1'b0);
          hc1    = char_in;
          hf1    = 1'b0;
        end else begin
          ca.v     = hv_r;
          ca.tok   = sct_pkg::flush_tok(mode_r, hc_r, hf_r, 1'b1);
          do_start = 1'b1;
        end
      end
      sct_pkg::M_STR_OPEN: begin
        if (char_in == sct_pkg::CH_QUOTE) begin
          ca.v   = 1'b1;
          ca.tok = sct_pkg::make_tok(sct_pkg::K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
          mode1  = sct_pkg::M_IDLE;
        end else begin
          mode1 = sct_pkg::M_STR;
          hc1   = char_in;
          hv1   = 1'b1;
          hf1   = 1'b1;
        end
      end
      sct_pkg::M_STR: begin
        if (char_in == sct_pkg::CH_QUOTE) begin
          ca.v   = hv_r;
          ca.tok = sct_pkg::flush_tok(mode_r, hc_r, hf_r, 1'b1);
          hv1    = 1'b0;
          mode1  = sct_pkg::M_IDLE;
        end else begin
          ca.v   = hv_r;
          ca.tok = sct_pkg::flush_tok(mode_r, hc_r, hf_r, 1'b0);
          hc1    = char_in;
          hv1    = 1'b1;
          hf1    = 1'b0;
        end
      end
      sct_pkg::M_OP: begin
        if (hv_r && pair.hit) begin
          ca.v   = 1'b1;
          ca.tok = sct_pkg::make_tok(pair.kind, hc_r, 1'b1, 1'b1, 1'b0);
          cb.v   = 1'b1;
          cb.tok = sct_pkg::make_tok(pair.kind, char_in, 1'b1, 1'b0, 1'b1);
          hv1    = 1'b0;
          mode1  = sct_pkg::M_IDLE;
        end else begin
          ca.v     = hv_r;
          ca.tok   = sct_pkg::flush_tok(mode_r, hc_r, hf_r, 1'b1);
          do_start = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Open a new token with the incoming character
    if (do_start) begin
      mode1 = sct_pkg::M_IDLE;
      hv1   = 1'b0;
      if (sct_pkg::is_space(char_in)) begin
        mode1 = sct_pkg::M_IDLE;
      end else if (sct_pkg::is_alpha(char_in) || (char_in == sct_pkg::CH_USCORE)) begin
        mode1 = sct_pkg::M_IDENT;
        hc1   = char_in;
        hv1   = 1'b1;
        hf1   = 1'b1;
      end else if (sct_pkg::is_digit(char_in)) begin
        mode1 = sct_pkg::M_NUMBER;
        hc1   = char_in;
        hv1   = 1'b1;
        hf1   = 1'b1;
      end else if (char_in == sct_pkg::CH_QUOTE) begin
        mode1 = sct_pkg::M_STR_OPEN;
      end else if (sct_pkg::is_op_start(char_in)) begin
        mode1 = sct_pkg::M_OP;
        hc1   = char_in;
        hv1   = 1'b1;
        hf1   = 1'b1;
      end else begin
        cb.v   = 1'b1;
        cb.tok = sct_pkg::make_tok(pk.hit ? pk.kind : sct_pkg::K_UNKNOWN,
                                   char_in, 1'b1, 1'b1, 1'b1);
      end
    end
  end

  // End of input closes whatever is open
  always_comb begin
    ce       = '0;
    mode_nxt = mode1;
    hc_nxt   = hc1;
    hv_nxt   = hv1;
    hf_nxt   = hf1;
    if (end_of_input) begin
      if (mode1 == sct_pkg::M_STR_OPEN) begin
        ce.v   = 1'b1;
        ce.tok = sct_pkg::make_tok(sct_pkg::K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
        ce.v   = hv1;
        ce.tok = sct_pkg::flush_tok(mode1, hc1, hf1, 1'b1);
      end
      mode_nxt = sct_pkg::M_IDLE;
      hv_nxt   = 1'b0;
    end
  end

  // Pack results in order and mark the last one
  always_comb begin
    n  = 2'd0;
    r0 = ca.tok;
    r1 = cb.tok;
    if (ca.v) begin
      r0 = ca.tok;
      n  = 2'd1;
    end
    if (cb.v) begin
      if (n == 2'd0) begin
        r0 = cb.tok;
      end else begin
        r1 = cb.tok;
      end
      n = n + 2'd1;
    end
    if (ce.v) begin
      if (n == 2'd0) begin
        r0 = ce.tok;
      end else begin
        r1 = ce.tok;
      end
      n = n + 2'd1;
    end
    if (n == 2'd1) begin
      r0.run_end = 1'b1;
    end else if (n == 2'd2) begin
      r1.run_end = 1'b1;
    end
    push.n    = take ? n : 2'd0;
    push.tok0 = r0;
    push.tok1 = r1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sct_pkg::M_IDLE;
      hc_r   <= 8'h00;
      hv_r   <= 1'b0;
      hf_r   <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      hv_r   <= hv_nxt;
      hf_r   <= hf_nxt;
    end
  end

  // A held character exists exactly in the modes that hold one
  a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r == ((mode_r == sct_pkg::M_IDENT) || (mode_r == sct_pkg::M_NUMBER) ||
             (mode_r == sct_pkg::M_STR) || (mode_r == sct_pkg::M_OP)))
    else $error("held_valid disagrees with lexer mode");

  // End of input leaves the lexer idle
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && end_of_input |=> (mode_r == sct_pkg::M_IDLE) && !hv_r)
    else $error("lexer not idle after end of input");

  // A pending operator is always settled by the next character
  a_op_resolves: assert property (@(posedge clk) disable iff (!rst_n)
    take && (mode_r == sct_pkg::M_OP) && hv_r |-> push.n != 2'd0)
    else $error("held operator produced no result");

endmodule

FILE: src/sct_queue.sv
// Three-entry result queue: takes up to two beats per cycle, sends one.
module sct_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  sct_pkg::push_t push,
  output logic           nearly_full,
  output logic           out_valid,
  input  logic           out_stall,
  output sct_pkg::tok_t  head
);

  sct_pkg::tok_t q_r   [sct_pkg::QDEPTH];
  sct_pkg::tok_t q_nxt [sct_pkg::QDEPTH];
  logic [1:0]    cnt_r, cnt_nxt, cnt_p;
  logic          pop;

  assign out_valid   = (cnt_r != 2'd0);
  assign pop         = out_valid && !out_stall;
  assign head        = q_r[0];
  // Room for two beats only when at most one is queued
  assign nearly_full = (cnt_r >= 2'd2);

  // Shift out on pop, then append new beats behind what remains
  always_comb begin
    for (int i = 0; i < sct_pkg::QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[sct_pkg::QDEPTH-1] = q_r[sct_pkg::QDEPTH-1];
    cnt_p = cnt_r - {1'b0, pop};
    if (push.n != 2'd0) begin
      q_nxt[cnt_p] = push.tok0;
    end
    if ((push.n == 2'd2) && ((cnt_p + 2'd1) < 2'(sct_pkg::QDEPTH))) begin
      q_nxt[cnt_p + 2'd1] = push.tok1;
    end
    cnt_nxt = cnt_p + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage, no reset needed
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Beats only arrive when there is room for them
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> cnt_r <= 2'd1)
    else $error("result queue overflow");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(sct_pkg::QDEPTH))
    else $error("result queue count out of range");

  // A stalled head stays put
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(head))
    else $error("stalled result changed");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the source code tokenizer: random source text, token predictor.
`timescale 1ns / 100ps

module testbench;

  // One source character as offered on the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_char_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_token_kind;
  logic [7:0] out_char_out;
  logic       out_has_char;
  logic       out_token_first;
  logic       out_token_last;
  logic       out_run_end;

  source_code_tokenizer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_char_out   (out_char_out),
    .out_has_char   (out_has_char),
    .out_token_first(out_token_first),
    .out_token_last (out_token_last),
    .out_run_end    (out_run_end)
  );

  src_char_t     source_q[$];
  sct_pkg::tok_t token_expect_q[$];
  src_char_t     drive_beat;
  sct_pkg::tok_t want_tok;
  int            chars_sent = 0;
  int            tokens_seen = 0;
  int            sources_built = 0;
  int            errors = 0;

  logic [7:0] op_chars [9] = '{sct_pkg::CH_EQ, sct_pkg::CH_LT, sct_pkg::CH_GT,
                               sct_pkg::CH_BANG, sct_pkg::CH_PLUS, sct_pkg::CH_MINUS,
                               sct_pkg::CH_STAR, sct_pkg::CH_SLASH, sct_pkg::CH_PCT};
  logic [7:0] punct_chars [10] = '{sct_pkg::CH_LPAREN, sct_pkg::CH_RPAREN,
                                   sct_pkg::CH_LBRACE, sct_pkg::CH_RBRACE,
                                   sct_pkg::CH_LBRKT, sct_pkg::CH_RBRKT,
                                   sct_pkg::CH_COMMA, sct_pkg::CH_COLON,
                                   sct_pkg::CH_SEMI, sct_pkg::CH_DOT};

  // No idling on either side during this window of sent characters
  wire calm = (chars_sent >= 400) && (chars_sent < 650);

  // Lexer state of the predictor
  sct_pkg::mode_t lx_mode = sct_pkg::M_IDLE;
  logic [7:0]     lx_held = 8'h00;
  logic           lx_held_ok = 1'b0;
  logic           lx_held_first = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- character classes ----------------
  function automatic logic blank_char(input logic [7:0] c);
    return (c == sct_pkg::CH_SPACE) || (c inside {[sct_pkg::CH_TAB:sct_pkg::CH_CR]});
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic op_char(input logic [7:0] c);
    return c inside {sct_pkg::CH_EQ, sct_pkg::CH_LT, sct_pkg::CH_GT, sct_pkg::CH_BANG,
                     sct_pkg::CH_PLUS, sct_pkg::CH_MINUS, sct_pkg::CH_STAR,
                     sct_pkg::CH_SLASH, sct_pkg::CH_PCT};
  endfunction

  function automatic logic [4:0] lone_op_kind(input logic [7:0] h);
    case (h)
      sct_pkg::CH_EQ:                 return sct_pkg::K_ASSIGN;
      sct_pkg::CH_LT, sct_pkg::CH_GT: return sct_pkg::K_COMPARE;
      default:                        return sct_pkg::K_OPERATOR;
    endcase
  endfunction

  // Two-character operator: returns 1 and its kind when h then c pair up
  function automatic logic paired_op(input logic [7:0] h, input logic [7:0] c,
                                     output logic [4:0] kind);
    kind = sct_pkg::K_OPERATOR;
    if ((h == sct_pkg::CH_LT || h == sct_pkg::CH_GT) && c == h) return 1'b1;
    if (c != sct_pkg::CH_EQ) return 1'b0;
    case (h)
      sct_pkg::CH_EQ, sct_pkg::CH_LT, sct_pkg::CH_GT, sct_pkg::CH_BANG:
        kind = sct_pkg::K_COMPARE;
      default:
        kind = sct_pkg::K_ASSIGN;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [4:0] single_char_kind(input logic [7:0] c);
    case (c)
      sct_pkg::CH_LPAREN: return sct_pkg::K_LPAREN;
      sct_pkg::CH_RPAREN: return sct_pkg::K_RPAREN;
      sct_pkg::CH_LBRACE: return sct_pkg::K_LBRACE;
      sct_pkg::CH_RBRACE: return sct_pkg::K_RBRACE;
      sct_pkg::CH_LBRKT:  return sct_pkg::K_LBRACKET;
      sct_pkg::CH_RBRKT:  return sct_pkg::K_RBRACKET;
      sct_pkg::CH_COMMA:  return sct_pkg::K_COMMA;
      sct_pkg::CH_COLON:  return sct_pkg::K_COLON;
      sct_pkg::CH_SEMI:   return sct_pkg::K_SEMI;
      sct_pkg::CH_DOT:    return sct_pkg::K_DOT;
      default:            return sct_pkg::K_UNKNOWN;
    endcase
  endfunction

  // ---------------- token predictor ----------------
  function automatic void push_token(input logic [4:0] kind, input logic [7:0] ch,
                                     input logic has, input logic first, input logic last);
    sct_pkg::tok_t t;
    t.kind     = kind;
    t.ch       = ch;
    t.has_char = has;
    t.first    = first;
    t.last     = last;
    t.run_end  = 1'b0;
    token_expect_q.push_back(t);
  endfunction

  function automatic void hold_char(input sct_pkg::mode_t m, input logic [7:0] c,
                                    input logic first);
    lx_mode       = m;
    lx_held       = c;
    lx_held_ok    = 1'b1;
    lx_held_first = first;
  endfunction

  // Report the held character, closing its token if last is set
  function automatic void release_held(input logic last);
    logic [4:0] k;
    if (!lx_held_ok) return;
    case (lx_mode)
      sct_pkg::M_IDENT:  k = sct_pkg::K_IDENT;
      sct_pkg::M_NUMBER: k = sct_pkg::K_NUMBER;
      sct_pkg::M_STR:    k = sct_pkg::K_STRING;
      default:           k = lone_op_kind(lx_held);
    endcase
    push_token(k, lx_held, 1'b1, lx_held_first, last);
    if (last) lx_held_ok = 1'b0;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    lx_mode    = sct_pkg::M_IDLE;
    lx_held_ok = 1'b0;
    if (blank_char(c)) return;
    if (letter_char(c) || c == sct_pkg::CH_USCORE) hold_char(sct_pkg::M_IDENT, c, 1'b1);
    else if (digit_char(c)) hold_char(sct_pkg::M_NUMBER, c, 1'b1);
    else if (c == sct_pkg::CH_QUOTE) lx_mode = sct_pkg::M_STR_OPEN;
    else if (op_char(c)) hold_char(sct_pkg::M_OP, c, 1'b1);
    else push_token(single_char_kind(c), c, 1'b1, 1'b1, 1'b1);
  endfunction

  // Expected results of one accepted character
  function automatic void lex_char(input logic [7:0] c, input logic eoi);
    int            n0;
    logic          cont;
    logic          pair_hit;
    logic [4:0]    pk;
    sct_pkg::tok_t t;
    n0 = token_expect_q.size();
    case (lx_mode)
      sct_pkg::M_IDENT, sct_pkg::M_NUMBER: begin
        cont = (lx_mode == sct_pkg::M_IDENT) ?
               (letter_char(c) || digit_char(c) || c == sct_pkg::CH_USCORE) :
               (digit_char(c) || c == sct_pkg::CH_DOT);
        if (cont && lx_held_ok) begin
          release_held(1'b0);
          hold_char(lx_mode, c, 1'b0);
        end else begin
          release_held(1'b1);
          open_token(c);
        end
      end
      sct_pkg::M_STR_OPEN: begin
        if (c == sct_pkg::CH_QUOTE) begin
          push_token(sct_pkg::K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
          lx_mode = sct_pkg::M_IDLE;
        end else begin
          hold_char(sct_pkg::M_STR, c, 1'b1);
        end
      end
      sct_pkg::M_STR: begin
        if (c == sct_pkg::CH_QUOTE) begin
          release_held(1'b1);
          lx_mode = sct_pkg::M_IDLE;
        end else begin
          release_held(1'b0);
          hold_char(sct_pkg::M_STR, c, 1'b0);
        end
      end
      sct_pkg::M_OP: begin
        pair_hit = paired_op(lx_held, c, pk);
        if (lx_held_ok && pair_hit) begin
          push_token(pk, lx_held, 1'b1, 1'b1, 1'b0);
          push_token(pk, c, 1'b1, 1'b0, 1'b1);
          lx_held_ok = 1'b0;
          lx_mode    = sct_pkg::M_IDLE;
        end else begin
          release_held(1'b1);
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
    // End of source closes whatever is open
    if (eoi) begin
      if (lx_mode == sct_pkg::M_STR_OPEN)
        push_token(sct_pkg::K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
      else release_held(1'b1);
      lx_mode    = sct_pkg::M_IDLE;
      lx_held_ok = 1'b0;
    end
    if (token_expect_q.size() > n0) begin
      t = token_expect_q.pop_back();
      t.run_end = 1'b1;
      token_expect_q.push_back(t);
    end
  endfunction

  // ---------------- source text generation ----------------
  task automatic add_char(input logic [7:0] c, input logic eoi = 1'b0);
    src_char_t s;
    s.ch  = c;
    s.eoi = eoi;
    source_q.push_back(s);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                             : 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(2) ? sct_pkg::CH_SPACE
                             : 8'($urandom_range(sct_pkg::CH_TAB, sct_pkg::CH_CR));
  endfunction

  // One source: a run of mostly well-formed tokens, last character flagged
  task automatic add_source();
    int        ntok;
    int        pick;
    logic [7:0] c;
    src_char_t s;
    ntok = $urandom_range(1, 10);
    for (int i = 0; i < ntok; i++) begin
      pick = $urandom_range(0, 15);
      if (pick <= 3) begin
        add_char($urandom_range(4) ? rand_letter() : sct_pkg::CH_USCORE);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 5))
            0:       add_char(rand_digit());
            1:       add_char(sct_pkg::CH_USCORE);
            default: add_char(rand_letter());
          endcase
        end
      end else if (pick <= 5) begin
        add_char(rand_digit());
        repeat ($urandom_range(0, 5))
          add_char($urandom_range(3) ? rand_digit() : sct_pkg::CH_DOT);
      end else if (pick <= 7) begin
        add_char(sct_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5))
          add_char($urandom_range(7) ? 8'($urandom_range(8'h20, 8'h7E))
                                     : 8'($urandom_range(0, 255)));
        if ($urandom_range(9) != 0) add_char(sct_pkg::CH_QUOTE);
      end else if (pick <= 9) begin
        c = op_chars[$urandom_range(0, 8)];
        add_char(c);
        case ($urandom_range(0, 3))
          0: add_char(sct_pkg::CH_EQ);
          1: add_char(c);
          default: ;
        endcase
      end else if (pick <= 11) begin
        add_char(punct_chars[$urandom_range(0, 9)]);
      end else if (pick == 12) begin
        add_char(8'($urandom_range(0, 255)));
      end else begin
        add_char(rand_blank());
      end
      if ($urandom_range(1)) add_char(rand_blank());
    end
    s = source_q.pop_back();
    s.eoi = 1'b1;
    source_q.push_back(s);
    sources_built++;
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        lex_char(in_char_in, in_end_of_input);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (source_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          drive_beat = source_q.pop_front();
          in_valid        <= 1'b1;
          in_char_in      <= drive_beat.ch;
          in_end_of_input <= drive_beat.eoi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  function automatic void check_field(input string what, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: token %0d %s mismatch, expected %0h, actual %0h",
                 $time, tokens_seen, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (token_expect_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected beat, expected none, actual kind %0d char %02h",
                     $time, out_token_kind, out_char_out);
        end else begin
          want_tok = token_expect_q.pop_front();
          check_field("kind", want_tok.kind, out_token_kind);
          check_field("char", want_tok.ch, out_char_out);
          check_field("has_char", want_tok.has_char, out_has_char);
          check_field("first", want_tok.first, out_token_first);
          check_field("last", want_tok.last, out_token_last);
          check_field("run_end", want_tok.run_end, out_run_end);
        end
        tokens_seen++;
      end
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    // Directed: identifier, number with dots, empty and plain strings,
    // paired and lone operators, byte extremes, dot as punctuation,
    // lone operator and open string at end of source
    add_char("a"); add_char(sct_pkg::CH_USCORE); add_char("9"); add_char(sct_pkg::CH_SPACE);
    add_char("1"); add_char(sct_pkg::CH_DOT); add_char("5"); add_char(sct_pkg::CH_DOT);
    add_char(sct_pkg::CH_QUOTE); add_char(sct_pkg::CH_QUOTE);
    add_char(sct_pkg::CH_QUOTE); add_char("q"); add_char(sct_pkg::CH_QUOTE);
    add_char(sct_pkg::CH_LT); add_char(sct_pkg::CH_LT);
    add_char(sct_pkg::CH_BANG); add_char(sct_pkg::CH_EQ);
    add_char(sct_pkg::CH_PLUS); add_char(sct_pkg::CH_LPAREN);
    add_char(8'h00); add_char(8'hFF); add_char(sct_pkg::CH_DOT);
    add_char(sct_pkg::CH_GT); add_char(sct_pkg::CH_EQ); add_char(sct_pkg::CH_MINUS, 1'b1);
    add_char(sct_pkg::CH_QUOTE, 1'b1);
    while (source_q.size() < 1125) add_source();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (source_q.size() > 0 || in_valid) @(posedge clk);
    while (token_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d sources plus directed text, checked %0d tokens beats",
             chars_sent, sources_built, tokens_seen);
    $display("Covered identifiers, numbers, strings, operators, punctuation and stray bytes");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Run timed out");
    $display("== FAIL ==");
    $finish;
  end

endmodule
